[rtl/core/jse_pkg.sv]
// Shared types, constants and helpers for the JSON string escaper.
`default_nettype none
package jse_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int CAP_WIDTH   = 16;
    // compare width: wide enough for used_count plus the longest escape, and for capacity
    localparam int CMP_WIDTH   = (COUNT_WIDTH + 1 > CAP_WIDTH + 1) ? COUNT_WIDTH + 1
                                                                   : CAP_WIDTH + 1;
    localparam logic [CAP_WIDTH-1:0] CAP_RESET = CAP_WIDTH'(256);

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // escape kinds
    localparam logic [1:0] KIND_PLAIN = 2'd0;
    localparam logic [1:0] KIND_PAIR  = 2'd1;
    localparam logic [1:0] KIND_UNI   = 2'd2;
    localparam logic [1:0] KIND_TERM  = 2'd3;

    localparam logic [2:0] LEN_PLAIN = 3'd1;
    localparam logic [2:0] LEN_PAIR  = 3'd2;
    localparam logic [2:0] LEN_UNI   = 3'd6;

    localparam logic [2:0] STEP_FIRST = 3'd0;
    localparam logic [2:0] STEP_PAIR_LAST = 3'd1;
    localparam logic [2:0] STEP_UNI_LAST  = 3'd5;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    typedef struct packed {
        logic [7:0] char_byte;
        logic [1:0] kind;
        logic       trunc;
    } t_entry;

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] res;
        if (nib < 4'd10) begin
            res = CH_ZERO + {4'd0, nib};
        end else begin
            res = 8'h57 + {4'd0, nib}; // 'a' - 10
        end
        return res;
    endfunction

endpackage
`default_nettype wire

[rtl/core/jse_front.sv]
// Front end: takes source bytes, classifies them, checks room and queues escape jobs.
`default_nettype none
module jse_front (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_wr_en,
    input  wire logic [jse_pkg::CAP_WIDTH-1:0] i_cfg_wr_data,
    input  wire logic                    i_in_valid,
    output logic                         o_in_stall,
    input  wire logic [7:0]              i_char_byte,
    input  wire logic                    i_q_full,
    output logic                         o_q_push,
    output jse_pkg::t_entry              o_q_entry
);

    logic [jse_pkg::CAP_WIDTH-1:0]   r_capacity;
    logic [jse_pkg::COUNT_WIDTH-1:0] r_used, n_used;
    logic                            r_halted, n_halted;

    logic [1:0]                      kind;
    logic [2:0]                      len;
    logic [jse_pkg::CMP_WIDTH-1:0]   total;
    logic                            no_room;
    logic                            accept;

    localparam logic [jse_pkg::CMP_WIDTH-1:0] COUNT_MAX =
        jse_pkg::CMP_WIDTH'((64'd1 << jse_pkg::COUNT_WIDTH) - 64'd1);

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;

    always_comb begin
        if (i_char_byte == jse_pkg::CH_NUL) begin
            kind = jse_pkg::KIND_TERM;
            len  = jse_pkg::LEN_PLAIN;
        end else if (i_char_byte inside {jse_pkg::CH_QUOTE, jse_pkg::CH_BSLASH,
                                         jse_pkg::CH_LF, jse_pkg::CH_CR, jse_pkg::CH_TAB}) begin
            kind = jse_pkg::KIND_PAIR;
            len  = jse_pkg::LEN_PAIR;
        end else if (i_char_byte < jse_pkg::CH_SPACE) begin
            kind = jse_pkg::KIND_UNI;
            len  = jse_pkg::LEN_UNI;
        end else begin
            kind = jse_pkg::KIND_PLAIN;
            len  = jse_pkg::LEN_PLAIN;
        end
    end

    assign total = jse_pkg::CMP_WIDTH'(r_used) + jse_pkg::CMP_WIDTH'(len);
    assign no_room = (total >= jse_pkg::CMP_WIDTH'(r_capacity)) || (total > COUNT_MAX);

    always_comb begin
        n_used              = r_used;
        n_halted            = r_halted;
        o_q_push            = 1'b0;
        o_q_entry.char_byte = i_char_byte;
        o_q_entry.kind      = kind;
        o_q_entry.trunc     = r_halted;
        if (accept) begin
            if (kind == jse_pkg::KIND_TERM) begin
                o_q_push = 1'b1;
                n_used   = '0;
                n_halted = 1'b0;
            end else if (!r_halted) begin
                if (no_room) begin
                    n_halted = 1'b1;
                end else begin
                    o_q_push = 1'b1;
                    n_used   = total[jse_pkg::COUNT_WIDTH-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= jse_pkg::CAP_RESET;
            r_used     <= '0;
            r_halted   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_capacity <= i_cfg_wr_data;
            end
            r_used   <= n_used;
            r_halted <= n_halted;
        end
    end

endmodule
`default_nettype wire

[rtl/core/jse_queue.sv]
// Short job queue between front and back ends.
`default_nettype none
module jse_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire jse_pkg::t_entry i_entry,
    output logic                 o_full,
    input  wire logic            i_pop,
    output logic                 o_valid,
    output jse_pkg::t_entry      o_entry
);

    jse_pkg::t_entry                r_mem [jse_pkg::QUEUE_DEPTH];
    logic [jse_pkg::QUEUE_AW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [jse_pkg::QUEUE_AW:0]     r_count;

    assign o_full  = (r_count == (jse_pkg::QUEUE_AW+1)'(jse_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

[rtl/core/jse_back.sv]
// Back end: expands queued jobs into escaped output bytes through an output register.
`default_nettype none
module jse_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_q_valid,
    input  wire jse_pkg::t_entry i_q_entry,
    output logic                 o_q_pop,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output logic [7:0]           o_out_byte,
    output logic                 o_run_last,
    output logic                 o_end_of_string,
    output logic                 o_truncated
);

    logic [2:0] r_step;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last, r_eos, r_trunc;

    logic       load_en;
    logic [7:0] byte_val;
    logic       is_last;
    logic [7:0] pair_char;

    assign load_en = !r_valid || !i_out_stall;

    always_comb begin
        case (i_q_entry.char_byte)
            jse_pkg::CH_QUOTE:  pair_char = jse_pkg::CH_QUOTE;
            jse_pkg::CH_BSLASH: pair_char = jse_pkg::CH_BSLASH;
            jse_pkg::CH_LF:     pair_char = jse_pkg::CH_N;
            jse_pkg::CH_CR:     pair_char = jse_pkg::CH_R;
            default:            pair_char = jse_pkg::CH_T;
        endcase
    end

    always_comb begin
        byte_val = jse_pkg::CH_BSLASH;
        is_last  = 1'b0;
        case (i_q_entry.kind)
            jse_pkg::KIND_PLAIN: begin
                byte_val = i_q_entry.char_byte;
                is_last  = 1'b1;
            end
            jse_pkg::KIND_TERM: begin
                byte_val = jse_pkg::CH_NUL;
                is_last  = 1'b1;
            end
            jse_pkg::KIND_PAIR: begin
                if (r_step != jse_pkg::STEP_FIRST) begin
                    byte_val = pair_char;
                end
                is_last = (r_step == jse_pkg::STEP_PAIR_LAST);
            end
            default: begin
                // \u00xx
                case (r_step)
                    3'd0:    byte_val = jse_pkg::CH_BSLASH;
                    3'd1:    byte_val = jse_pkg::CH_U;
                    3'd4:    byte_val = jse_pkg::hex_digit(i_q_entry.char_byte[7:4]);
                    3'd5:    byte_val = jse_pkg::hex_digit(i_q_entry.char_byte[3:0]);
                    default: byte_val = jse_pkg::CH_ZERO;
                endcase
                is_last = (r_step == jse_pkg::STEP_UNI_LAST);
            end
        endcase
    end

    assign o_q_pop = load_en && i_q_valid && is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= jse_pkg::STEP_FIRST;
            r_valid <= 1'b0;
        end else if (load_en) begin
            r_valid <= i_q_valid;
            if (i_q_valid) begin
                r_step <= is_last ? jse_pkg::STEP_FIRST : r_step + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_en && i_q_valid) begin
            r_byte  <= byte_val;
            r_last  <= is_last;
            r_eos   <= (i_q_entry.kind == jse_pkg::KIND_TERM);
            r_trunc <= (i_q_entry.kind == jse_pkg::KIND_TERM) && i_q_entry.trunc;
        end
    end

    assign o_out_valid     = r_valid;
    assign o_out_byte      = r_byte;
    assign o_run_last      = r_last;
    assign o_end_of_string = r_eos;
    assign o_truncated     = r_trunc;

endmodule
`default_nettype wire

[rtl/core/json_string_escaper_core.sv]
// Top level of the JSON string escaper: front end, job queue and back end.
// One source byte enters per cycle while the 4-entry job queue has room. The output
// side emits one byte per cycle while i_out_stall is low: a plain byte or the terminator
// gives one output byte, a two-character escape two and a \u00xx escape six, so the
// back end's byte sequencer sets the sustained rate on escape-heavy text. Bytes pass
// through the job queue and the back end's output register. Room checks against
// buffer_capacity happen as the byte enters; a byte that does not fit, and every later
// one up to the zero terminator, yields no output; the terminator then carries o_truncated.
`default_nettype none
module json_string_escaper_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [jse_pkg::CAP_WIDTH-1:0]  i_cfg_wr_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [7:0]                     i_char_byte,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [7:0]                          o_out_byte,
    output logic                                o_run_last,
    output logic                                o_end_of_string,
    output logic                                o_truncated
);

    logic            q_push, q_full, q_pop, q_valid;
    jse_pkg::t_entry push_entry, head_entry;

    jse_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_char_byte   (i_char_byte),
        .i_q_full      (q_full),
        .o_q_push      (q_push),
        .o_q_entry     (push_entry)
    );

    jse_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (push_entry),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_entry (head_entry)
    );

    jse_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_q_entry       (head_entry),
        .o_q_pop         (q_pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_byte      (o_out_byte),
        .o_run_last      (o_run_last),
        .o_end_of_string (o_end_of_string),
        .o_truncated     (o_truncated)
    );

endmodule
`default_nettype wire
